// ===== hdl/adsr_envelope_gain_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ADSR envelope gain block
// Shared shorthand for clocked assertions that use clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_GAIN_MACROS_SVH
`define ADSR_ENVELOPE_GAIN_MACROS_SVH

// Property that must hold at every edge outside reset.
`define ADSR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at an edge outside reset.
`define ADSR_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// Types and constants shared by the ADSR envelope gain block and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int WORD_BITS    = 24;
	localparam int MUL_A_BITS   = (SAMPLE_BITS > WORD_BITS) ? SAMPLE_BITS : WORD_BITS;
	localparam int MUL_P_BITS   = MUL_A_BITS + WORD_BITS;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [WORD_BITS-1:0] GAIN_ONE  = 24'd8388608;
	localparam logic [WORD_BITS-1:0] REM_FULL  = 24'hFFFFFF;
	localparam logic [WORD_BITS-1:0] COUNT_MAX = 24'hFFFFFF;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		CMD_SAMPLE   = 2'd0,
		CMD_GATE_ON  = 2'd1,
		CMD_GATE_OFF = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ATTACK_COEF    = 3'd0,
		REG_DECAY_COEF     = 3'd1,
		REG_RELEASE_COEF   = 3'd2,
		REG_SUSTAIN_LEVEL  = 3'd3,
		REG_ATTACK_LENGTH  = 3'd4,
		REG_DECAY_LENGTH   = 3'd5,
		REG_RELEASE_LENGTH = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_READY  = 3'd0,
		ST_REM    = 3'd1,
		ST_GAIN   = 3'd2,
		ST_SCALE  = 3'd3,
		ST_FINISH = 3'd4
	} seq_state_t;

endpackage

`default_nettype wire

// ===== hdl/adsr_envelope_gain.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_gain
// Exponential ADSR envelope applied to a mono sample stream.
// ----------------------------------------------------------------------------
// Each input item is a sample, a gate-on or a gate-off, and each gives one
// result item. One item is worked on at a time, through a single shared
// multiplier of SAMPLE_BITS by 24 bits: a sample in attack, decay or release
// goes through remainder update, gain, scaling and result before the next
// acceptance, a sample in idle or sustain through scaling and result only,
// and a gate or unused command through the result alone. A finished result
// waits in the output register while the next item is taken; the block stalls
// only when that register is still full as the following result is ready.
`timescale 1ns / 1ps
`default_nettype none

module adsr_envelope_gain (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [1:0]                             command,
	input  logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic [adsr_pkg::WORD_BITS-1:0]          gain_out,
	output logic [2:0]                             phase_out,
	input  logic                                   cfg_we,
	input  logic [adsr_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [adsr_pkg::WORD_BITS-1:0]          cfg_data
);

	localparam int SB = adsr_pkg::SAMPLE_BITS;
	localparam int WB = adsr_pkg::WORD_BITS;
	localparam int AB = adsr_pkg::MUL_A_BITS;
	localparam int PB = adsr_pkg::MUL_P_BITS;
	localparam int SCB = PB - (WB - 1);

	logic [WB-1:0] attack_coef_q, decay_coef_q, release_coef_q, sustain_level_q;
	logic [WB-1:0] attack_length_q, decay_length_q, release_length_q;

	adsr_pkg::seq_state_t state_q, state_d;
	adsr_pkg::phase_t     phase_q;
	adsr_pkg::phase_t     next_phase;
	adsr_pkg::cmd_t       in_cmd;

	logic [WB-1:0] count_q, rem_q, offset_q, gain_q;
	logic [SB-1:0] sample_q, sout_q, sample_out_q;
	logic [WB-1:0] gain_out_q;
	logic [2:0]    phase_out_q;
	logic          out_valid_q;

	logic          accept, out_free;
	logic [WB-1:0] sus, g0, dec_diff, coef;
	logic          dec_neg, sample_neg;
	logic [SB-1:0] sample_mag;
	logic [AB-1:0] mul_a;
	logic [WB-1:0] mul_b;
	logic [PB-1:0] mul_p, rnd_const, mul_rnd;
	logic [WB-1:0] rnd24;
	logic [WB:0]   rem_inc;
	logic [WB-1:0] att_gain, dec_gain, gain_new;
	logic signed [WB+1:0] dec_sum;
	logic          phase_exit;
	logic [SCB-1:0] sc_p, sc_lim;
	logic [SB-1:0]  sc_mag, sc_out;

	assign in_ready   = (state_q == adsr_pkg::ST_READY);
	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign in_cmd     = adsr_pkg::cmd_t'(command);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign gain_out   = gain_out_q;
	assign phase_out  = phase_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_coef_q    <= 24'd16773120;
			decay_coef_q     <= 24'd16773120;
			release_coef_q   <= 24'd16773120;
			sustain_level_q  <= 24'd4194304;
			attack_length_q  <= 24'd20000;
			decay_length_q   <= 24'd20000;
			release_length_q <= 24'd20000;
		end else if (cfg_we) begin
			case (adsr_pkg::cfg_reg_t'(cfg_index))
				adsr_pkg::REG_ATTACK_COEF:    attack_coef_q    <= cfg_data;
				adsr_pkg::REG_DECAY_COEF:     decay_coef_q     <= cfg_data;
				adsr_pkg::REG_RELEASE_COEF:   release_coef_q   <= cfg_data;
				adsr_pkg::REG_SUSTAIN_LEVEL:  sustain_level_q  <= cfg_data;
				adsr_pkg::REG_ATTACK_LENGTH:  attack_length_q  <= cfg_data;
				adsr_pkg::REG_DECAY_LENGTH:   decay_length_q   <= cfg_data;
				adsr_pkg::REG_RELEASE_LENGTH: release_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adsr_pkg::ST_READY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			adsr_pkg::ST_READY: begin
				if (accept) begin
					case (in_cmd)
						adsr_pkg::CMD_SAMPLE: begin
							if (phase_q == adsr_pkg::PH_ATTACK || phase_q == adsr_pkg::PH_DECAY
								|| phase_q == adsr_pkg::PH_RELEASE) begin
								state_d = adsr_pkg::ST_REM;
							end else begin
								state_d = adsr_pkg::ST_SCALE;
							end
						end
						default: state_d = adsr_pkg::ST_FINISH;
					endcase
				end
			end
			adsr_pkg::ST_REM:   state_d = adsr_pkg::ST_GAIN;
			adsr_pkg::ST_GAIN:  state_d = adsr_pkg::ST_SCALE;
			adsr_pkg::ST_SCALE: state_d = adsr_pkg::ST_FINISH;
			adsr_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = adsr_pkg::ST_READY;
				end
			end
			default: state_d = adsr_pkg::ST_READY;
		endcase
	end

	// Operand selection for the shared multiplier and the arithmetic around it.
	always_comb begin
		sus        = (sustain_level_q > adsr_pkg::GAIN_ONE) ? adsr_pkg::GAIN_ONE : sustain_level_q;
		g0         = (offset_q > adsr_pkg::GAIN_ONE) ? adsr_pkg::GAIN_ONE : offset_q;
		dec_neg    = (offset_q < sus);
		dec_diff   = dec_neg ? (sus - offset_q) : (offset_q - sus);
		sample_neg = sample_q[SB-1];
		sample_mag = sample_neg ? (~sample_q + SB'(1)) : sample_q;

		case (phase_q)
			adsr_pkg::PH_ATTACK: coef = attack_coef_q;
			adsr_pkg::PH_DECAY:  coef = decay_coef_q;
			default:             coef = release_coef_q;
		endcase

		case (state_q)
			adsr_pkg::ST_REM: begin
				mul_a = AB'(rem_q);
				mul_b = coef;
			end
			adsr_pkg::ST_GAIN: begin
				mul_a = (phase_q == adsr_pkg::PH_DECAY) ? AB'(dec_diff) : AB'(g0);
				mul_b = rem_q;
			end
			adsr_pkg::ST_SCALE: begin
				mul_a = AB'(sample_mag);
				mul_b = gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase

		mul_p     = PB'(mul_a) * PB'(mul_b);
		rnd_const = (state_q == adsr_pkg::ST_SCALE) ? (PB'(1) << (WB - 2)) : (PB'(1) << (WB - 1));
		mul_rnd   = mul_p + rnd_const;
		rnd24     = mul_rnd[2*WB-1:WB];

		rem_inc  = {1'b0, rem_q} + (WB+1)'(1);
		att_gain = adsr_pkg::GAIN_ONE - rem_inc[WB:1];

		if (dec_neg) begin
			dec_sum = $signed({2'b00, sus}) - $signed({2'b00, rnd24});
		end else begin
			dec_sum = $signed({2'b00, sus}) + $signed({2'b00, rnd24});
		end
		if (dec_sum < 0) begin
			dec_gain = '0;
		end else if (dec_sum > $signed({2'b00, adsr_pkg::GAIN_ONE})) begin
			dec_gain = adsr_pkg::GAIN_ONE;
		end else begin
			dec_gain = dec_sum[WB-1:0];
		end

		case (phase_q)
			adsr_pkg::PH_ATTACK: begin
				gain_new   = att_gain;
				phase_exit = (count_q >= attack_length_q);
				next_phase = adsr_pkg::PH_DECAY;
			end
			adsr_pkg::PH_DECAY: begin
				gain_new   = dec_gain;
				phase_exit = (count_q >= decay_length_q) || (dec_gain < sus);
				next_phase = adsr_pkg::PH_SUSTAIN;
			end
			adsr_pkg::PH_RELEASE: begin
				gain_new   = rnd24;
				phase_exit = (count_q >= release_length_q);
				next_phase = adsr_pkg::PH_IDLE;
			end
			default: begin
				gain_new   = gain_q;
				phase_exit = 1'b0;
				next_phase = phase_q;
			end
		endcase

		sc_p   = mul_rnd[PB-1:WB-1];
		sc_lim = sample_neg ? (SCB'(1) << (SB - 1)) : ((SCB'(1) << (SB - 1)) - SCB'(1));
		sc_mag = (sc_p > sc_lim) ? sc_lim[SB-1:0] : sc_p[SB-1:0];
		sc_out = sample_neg ? (~sc_mag + SB'(1)) : sc_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= adsr_pkg::PH_IDLE;
			count_q  <= '0;
			rem_q    <= adsr_pkg::REM_FULL;
			offset_q <= '0;
			gain_q   <= '0;
		end else begin
			case (state_q)
				adsr_pkg::ST_READY: begin
					if (accept) begin
						case (in_cmd)
							adsr_pkg::CMD_GATE_ON: begin
								count_q  <= '0;
								rem_q    <= adsr_pkg::REM_FULL;
								offset_q <= gain_q;
								phase_q  <= adsr_pkg::PH_ATTACK;
							end
							adsr_pkg::CMD_GATE_OFF: begin
								count_q  <= '0;
								rem_q    <= adsr_pkg::REM_FULL;
								offset_q <= gain_q;
								phase_q  <= adsr_pkg::PH_RELEASE;
							end
							adsr_pkg::CMD_SAMPLE: begin
								if (phase_q == adsr_pkg::PH_IDLE) begin
									gain_q <= '0;
								end else if (phase_q != adsr_pkg::PH_SUSTAIN
									&& count_q != adsr_pkg::COUNT_MAX) begin
									count_q <= count_q + WB'(1);
								end
							end
							default: ;
						endcase
					end
				end
				adsr_pkg::ST_REM: rem_q <= rnd24;
				adsr_pkg::ST_GAIN: begin
					if (phase_exit) begin
						count_q  <= '0;
						rem_q    <= adsr_pkg::REM_FULL;
						offset_q <= gain_new;
						phase_q  <= next_phase;
						gain_q   <= (next_phase == adsr_pkg::PH_IDLE) ? '0 : gain_new;
					end else begin
						gain_q <= gain_new;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == adsr_pkg::ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_in;
			sout_q   <= '0;
		end else if (state_q == adsr_pkg::ST_SCALE) begin
			sout_q <= sc_out;
		end
		if (state_q == adsr_pkg::ST_FINISH && out_free) begin
			sample_out_q <= sout_q;
			gain_out_q   <= gain_q;
			phase_out_q  <= phase_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/adsr_envelope_gain_checker.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_gain_checker
// Port-level checks of the ADSR envelope gain block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "adsr_envelope_gain_macros.svh"

module adsr_envelope_gain_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [adsr_pkg::SAMPLE_BITS-1:0] sample_out,
	input logic [adsr_pkg::WORD_BITS-1:0]   gain_out,
	input logic [2:0]                       phase_out
);

	`ADSR_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "ready after an accepted item")
	`ADSR_ASSERT_NEVER(a_gain_bound, out_valid && gain_out > adsr_pkg::GAIN_ONE, "gain above unity")
	`ADSR_ASSERT(a_idle_silent, out_valid && phase_out == adsr_pkg::PH_IDLE |-> gain_out == '0, "idle gain not zero")
	`ADSR_ASSERT(a_result_held, out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(gain_out), "result changed while stalled")

endmodule

bind adsr_envelope_gain adsr_envelope_gain_checker u_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope gain testbench
// Drives gate and sample items through the envelope block over valid/ready,
// predicts every result with an independent model of the envelope arithmetic,
// and checks each result field by field, under several register settings and
// under varying sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [adsr_pkg::SAMPLE_BITS-1:0] SMP_MAX =
		{1'b0, {(adsr_pkg::SAMPLE_BITS-1){1'b1}}};
	localparam logic [adsr_pkg::SAMPLE_BITS-1:0] SMP_MIN =
		{1'b1, {(adsr_pkg::SAMPLE_BITS-1){1'b0}}};
	localparam logic [adsr_pkg::WORD_BITS-1:0] WORD_MAX = {adsr_pkg::WORD_BITS{1'b1}};

	typedef struct {
		logic signed [adsr_pkg::SAMPLE_BITS-1:0] smp;
		logic [adsr_pkg::WORD_BITS-1:0]          gain;
		adsr_pkg::phase_t                        ph;
	} env_result_t;

	logic                                    clk;
	logic                                    arst_n;
	logic                                    in_valid;
	logic                                    in_ready;
	logic [1:0]                              command;
	logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_in;
	logic                                    out_valid;
	logic                                    out_ready;
	logic signed [adsr_pkg::SAMPLE_BITS-1:0] sample_out;
	logic [adsr_pkg::WORD_BITS-1:0]          gain_out;
	logic [2:0]                              phase_out;
	logic                                    cfg_we;
	logic [adsr_pkg::CFG_IDX_BITS-1:0]       cfg_index;
	logic [adsr_pkg::WORD_BITS-1:0]          cfg_data;

	env_result_t pending_results[$];
	int mismatches = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;

	adsr_pkg::phase_t               env_phase;
	logic [adsr_pkg::WORD_BITS-1:0] env_count;
	logic [adsr_pkg::WORD_BITS-1:0] env_rem;
	logic [adsr_pkg::WORD_BITS-1:0] env_offset;
	logic [adsr_pkg::WORD_BITS-1:0] env_gain;
	logic [adsr_pkg::WORD_BITS-1:0] env_regs [0:6];

	adsr_envelope_gain uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.gain_out(gain_out),
		.phase_out(phase_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void enter_phase(input adsr_pkg::phase_t next);
		env_count = '0;
		env_rem = adsr_pkg::REM_FULL;
		env_offset = env_gain;
		env_phase = next;
	endfunction

	function automatic void fade_remainder(input logic [adsr_pkg::WORD_BITS-1:0] coef);
		logic [63:0] prod;
		prod = 64'(env_rem) * 64'(coef) + 64'd8388608;
		env_rem = prod[47:24];
	endfunction

	function automatic logic [adsr_pkg::SAMPLE_BITS-1:0] scale_by_gain(
			input logic [adsr_pkg::SAMPLE_BITS-1:0] smp);
		logic [adsr_pkg::SAMPLE_BITS-1:0] mag;
		logic [63:0] prod;
		logic [63:0] top;
		mag = smp[adsr_pkg::SAMPLE_BITS-1] ? -smp : smp;
		prod = (64'(mag) * 64'(env_gain) + 64'd4194304) >> 23;
		top = 64'd1 << (adsr_pkg::SAMPLE_BITS - 1);
		if (smp[adsr_pkg::SAMPLE_BITS-1]) begin
			if (prod > top)
				prod = top;
			return -prod[adsr_pkg::SAMPLE_BITS-1:0];
		end
		if (prod > top - 64'd1)
			prod = top - 64'd1;
		return prod[adsr_pkg::SAMPLE_BITS-1:0];
	endfunction

	function automatic env_result_t envelope_step(input logic [1:0] cmd,
			input logic [adsr_pkg::SAMPLE_BITS-1:0] smp);
		env_result_t res;
		logic [adsr_pkg::WORD_BITS-1:0] sus;
		logic [adsr_pkg::WORD_BITS-1:0] span;
		logic [adsr_pkg::WORD_BITS-1:0] g0;
		logic [63:0] prod;
		longint g;
		logic below;
		res.smp = '0;
		sus = (env_regs[adsr_pkg::REG_SUSTAIN_LEVEL] > adsr_pkg::GAIN_ONE)
			? adsr_pkg::GAIN_ONE : env_regs[adsr_pkg::REG_SUSTAIN_LEVEL];
		case (cmd)
			adsr_pkg::CMD_GATE_ON: enter_phase(adsr_pkg::PH_ATTACK);
			adsr_pkg::CMD_GATE_OFF: enter_phase(adsr_pkg::PH_RELEASE);
			adsr_pkg::CMD_SAMPLE: begin
				if (env_phase inside {adsr_pkg::PH_ATTACK, adsr_pkg::PH_DECAY,
					adsr_pkg::PH_RELEASE} && env_count != adsr_pkg::COUNT_MAX)
					env_count = env_count + 1'b1;
				case (env_phase)
					adsr_pkg::PH_IDLE: env_gain = '0;
					adsr_pkg::PH_ATTACK: begin
						fade_remainder(env_regs[adsr_pkg::REG_ATTACK_COEF]);
						env_gain = adsr_pkg::GAIN_ONE - 24'((25'(env_rem) + 25'd1) >> 1);
						if (env_count >= env_regs[adsr_pkg::REG_ATTACK_LENGTH])
							enter_phase(adsr_pkg::PH_DECAY);
					end
					adsr_pkg::PH_DECAY: begin
						below = env_offset < sus;
						span = below ? sus - env_offset : env_offset - sus;
						fade_remainder(env_regs[adsr_pkg::REG_DECAY_COEF]);
						prod = (64'(span) * 64'(env_rem) + 64'd8388608) >> 24;
						g = below ? longint'(sus) - longint'(prod) : longint'(sus) + longint'(prod);
						if (g < 0)
							g = 0;
						if (g > longint'(adsr_pkg::GAIN_ONE))
							g = longint'(adsr_pkg::GAIN_ONE);
						env_gain = g[adsr_pkg::WORD_BITS-1:0];
						if (env_count >= env_regs[adsr_pkg::REG_DECAY_LENGTH] || env_gain < sus)
							enter_phase(adsr_pkg::PH_SUSTAIN);
					end
					adsr_pkg::PH_RELEASE: begin
						g0 = (env_offset > adsr_pkg::GAIN_ONE) ? adsr_pkg::GAIN_ONE : env_offset;
						fade_remainder(env_regs[adsr_pkg::REG_RELEASE_COEF]);
						prod = 64'(g0) * 64'(env_rem) + 64'd8388608;
						env_gain = prod[47:24];
						if (env_count >= env_regs[adsr_pkg::REG_RELEASE_LENGTH]) begin
							enter_phase(adsr_pkg::PH_IDLE);
							env_gain = '0;
						end
					end
					default: ;
				endcase
				res.smp = scale_by_gain(smp);
			end
			default: ;
		endcase
		res.gain = env_gain;
		res.ph = env_phase;
		return res;
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	task automatic send_item(input logic [1:0] cmd,
			input logic [adsr_pkg::SAMPLE_BITS-1:0] smp);
		int gap;
		gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		sample_in <= smp;
		do
			@(posedge clk);
		while (!in_ready);
		pending_results.push_back(envelope_step(cmd, smp));
		items_sent++;
	endtask

	task automatic wait_drained;
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input adsr_pkg::cfg_reg_t idx,
			input logic [adsr_pkg::WORD_BITS-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		env_regs[idx] = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [adsr_pkg::SAMPLE_BITS-1:0] random_sample;
		logic [adsr_pkg::SAMPLE_BITS-1:0] smp;
		smp = adsr_pkg::SAMPLE_BITS'($urandom);
		case ($urandom_range(15))
			0: smp = SMP_MAX;
			1: smp = SMP_MIN;
			2: smp = '0;
			3: smp = '1;
			default: ;
		endcase
		return smp;
	endfunction

	function automatic logic [adsr_pkg::WORD_BITS-1:0] random_coef;
		case ($urandom_range(4))
			0: return '0;
			1: return WORD_MAX;
			2: return adsr_pkg::WORD_BITS'($urandom);
			default: return adsr_pkg::WORD_BITS'($urandom_range(24'hFFFFFF, 24'hC00000));
		endcase
	endfunction

	function automatic logic [adsr_pkg::WORD_BITS-1:0] random_length;
		case ($urandom_range(11))
			0: return '0;
			1: return WORD_MAX;
			default: return adsr_pkg::WORD_BITS'($urandom_range(1, 10));
		endcase
	endfunction

	task automatic load_random_settings;
		logic [adsr_pkg::WORD_BITS-1:0] sus;
		case ($urandom_range(4))
			0: sus = '0;
			1: sus = adsr_pkg::GAIN_ONE;
			2: sus = adsr_pkg::WORD_BITS'($urandom);
			default: sus = adsr_pkg::WORD_BITS'($urandom_range(0, 8388608));
		endcase
		write_reg(adsr_pkg::REG_ATTACK_COEF, random_coef());
		write_reg(adsr_pkg::REG_DECAY_COEF, random_coef());
		write_reg(adsr_pkg::REG_RELEASE_COEF, random_coef());
		write_reg(adsr_pkg::REG_SUSTAIN_LEVEL, sus);
		write_reg(adsr_pkg::REG_ATTACK_LENGTH, random_length());
		write_reg(adsr_pkg::REG_DECAY_LENGTH, random_length());
		write_reg(adsr_pkg::REG_RELEASE_LENGTH, random_length());
	endtask

	task automatic send_samples(input int count);
		repeat (count) send_item(adsr_pkg::CMD_SAMPLE, random_sample());
	endtask

	task automatic test_idle_and_gates;
		send_item(adsr_pkg::CMD_SAMPLE, SMP_MAX);
		send_item(CMD_UNUSED, SMP_MIN);
		send_item(adsr_pkg::CMD_GATE_ON, '0);
		send_item(adsr_pkg::CMD_SAMPLE, SMP_MAX);
		send_item(adsr_pkg::CMD_SAMPLE, SMP_MIN);
		send_item(adsr_pkg::CMD_SAMPLE, '1);
		send_item(adsr_pkg::CMD_SAMPLE, '0);
		send_item(adsr_pkg::CMD_GATE_OFF, SMP_MAX);
		send_item(adsr_pkg::CMD_SAMPLE, adsr_pkg::SAMPLE_BITS'(1));
		send_item(adsr_pkg::CMD_GATE_ON, '1);
		send_item(adsr_pkg::CMD_GATE_OFF, '0);
		wait_drained();
	endtask

	task automatic test_unity_extremes;
		write_reg(adsr_pkg::REG_ATTACK_COEF, '0);
		write_reg(adsr_pkg::REG_DECAY_COEF, '0);
		write_reg(adsr_pkg::REG_RELEASE_COEF, '0);
		write_reg(adsr_pkg::REG_SUSTAIN_LEVEL, WORD_MAX);
		write_reg(adsr_pkg::REG_ATTACK_LENGTH, '0);
		write_reg(adsr_pkg::REG_DECAY_LENGTH, adsr_pkg::WORD_BITS'(2));
		write_reg(adsr_pkg::REG_RELEASE_LENGTH, adsr_pkg::WORD_BITS'(1));
		send_item(adsr_pkg::CMD_GATE_ON, '0);
		send_item(adsr_pkg::CMD_SAMPLE, SMP_MAX);
		send_item(adsr_pkg::CMD_SAMPLE, SMP_MIN);
		send_item(adsr_pkg::CMD_SAMPLE, '1);
		send_item(adsr_pkg::CMD_SAMPLE, SMP_MIN);
		send_item(adsr_pkg::CMD_GATE_OFF, '0);
		send_item(adsr_pkg::CMD_SAMPLE, SMP_MAX);
		send_item(adsr_pkg::CMD_SAMPLE, SMP_MIN);
		send_item(CMD_UNUSED, SMP_MAX);
		wait_drained();
	endtask

	task automatic test_backpressure;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		write_reg(adsr_pkg::REG_ATTACK_COEF, WORD_MAX);
		write_reg(adsr_pkg::REG_ATTACK_LENGTH, WORD_MAX);
		hold_request = 80;
		send_item(adsr_pkg::CMD_GATE_ON, '0);
		send_samples(23);
		wait_drained();
	endtask

	task automatic test_random_envelopes(input int idle_pct, input int stall_pct,
			input int count);
		int target;
		target = items_sent + count;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		load_random_settings();
		while (items_sent < target) begin
			if ($urandom_range(9) == 0) begin
				send_item(2'($urandom_range(3)), random_sample());
			end else begin
				send_item(adsr_pkg::CMD_GATE_ON, random_sample());
				send_samples($urandom_range(1, 14));
				send_item(adsr_pkg::CMD_GATE_OFF, random_sample());
				send_samples($urandom_range(1, 10));
			end
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		env_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				log_mismatch($sformatf("unexpected item: sample_out %0d gain_out %0d phase_out %0d",
					sample_out, gain_out, phase_out));
			end else begin
				want = pending_results.pop_front();
				if (sample_out !== want.smp || gain_out !== want.gain || phase_out !== want.ph)
					log_mismatch($sformatf({"mismatch: sample_out exp %0d got %0d, ",
						"gain_out exp %0d got %0d, phase_out exp %0d got %0d"},
						want.smp, sample_out, want.gain, gain_out, want.ph, phase_out));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= adsr_pkg::CMD_SAMPLE;
		sample_in <= '0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= adsr_pkg::REG_ATTACK_COEF;
		cfg_data <= '0;
		env_regs[adsr_pkg::REG_ATTACK_COEF] = 24'd16773120;
		env_regs[adsr_pkg::REG_DECAY_COEF] = 24'd16773120;
		env_regs[adsr_pkg::REG_RELEASE_COEF] = 24'd16773120;
		env_regs[adsr_pkg::REG_SUSTAIN_LEVEL] = 24'd4194304;
		env_regs[adsr_pkg::REG_ATTACK_LENGTH] = 24'd20000;
		env_regs[adsr_pkg::REG_DECAY_LENGTH] = 24'd20000;
		env_regs[adsr_pkg::REG_RELEASE_LENGTH] = 24'd20000;
		env_phase = adsr_pkg::PH_IDLE;
		env_count = '0;
		env_rem = adsr_pkg::REM_FULL;
		env_offset = '0;
		env_gain = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_and_gates();
		test_unity_extremes();
		test_backpressure();
		test_random_envelopes(0, 0, 125);
		test_random_envelopes(51, 0, 125);
		test_random_envelopes(0, 51, 125);
		test_random_envelopes(24, 24, 125);
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
